// ----- hw/rtl/cplr_pkg.sv -----
// Shared types and constants for the closed polygon line rasterizer.
`default_nettype none

package cplr_pkg;

  // Coordinate and Bresenham error widths
  localparam int COORD_W = 5;
  localparam int ERR_W   = 7;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // One line segment for the walker: start, end, and whether its final
  // pixel closes out the vertex that caused it
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic   tag_last;
  } seg_t;

  // Segment queue status seen by the front end
  typedef struct packed {
    logic full;
    logic room2;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cplr_fifo.sv -----
// Short segment queue between the vertex front end and the line walker.
`default_nettype none

module cplr_fifo
  import cplr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire seg_t    push_data,
  input  wire logic    pop,
  output seg_t         head,
  output logic         not_empty,
  output q_stat_t      stat
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  seg_t               mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     count_r, count_nxt;

  // Store a word on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign not_empty  = (count_r != '0);
  assign stat.full  = (count_r == (PTR_W+1)'(DEPTH));
  assign stat.room2 = (count_r <= (PTR_W+1)'(DEPTH - 2));

endmodule

`default_nettype wire

// ----- hw/rtl/cplr_front.sv -----
// Vertex front end: clamps vertices, tracks the polygon, queues segments.
`default_nettype none

module cplr_front
  import cplr_pkg::*;
#(
  parameter int GRID_SIZE = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire coord_t  in_vertex_x,
  input  wire coord_t  in_vertex_y,
  input  wire logic    in_last_vertex,
  input  wire q_stat_t q_stat,
  output logic         push,
  output seg_t         push_data
);

  // Largest coordinate that the grid holds
  localparam int     GRID_CAP = (GRID_SIZE > (1 << COORD_W)) ? (1 << COORD_W) : GRID_SIZE;
  localparam coord_t CMAX     = COORD_W'(GRID_CAP - 1);

  coord_t first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic   have_prev_r;
  logic   pend_r;
  seg_t   pend_seg_r;
  coord_t vx, vy;
  logic   accept;
  seg_t   seg_new;

  // Saturate coordinates beyond the grid
  assign vx = (in_vertex_x > CMAX) ? CMAX : in_vertex_x;
  assign vy = (in_vertex_y > CMAX) ? CMAX : in_vertex_y;

  assign in_ready = !pend_r && q_stat.room2;
  assign accept   = in_valid && in_ready;

  // Segment caused directly by the incoming vertex
  always_comb begin
    if (have_prev_r) begin
      seg_new.x0       = prev_x_r;
      seg_new.y0       = prev_y_r;
      seg_new.tag_last = !in_last_vertex;
    end else begin
      seg_new.x0       = vx;
      seg_new.y0       = vy;
      seg_new.tag_last = 1'b1;
    end
    seg_new.x1 = vx;
    seg_new.y1 = vy;
  end

  // Push the new segment on accept, or the held closing segment later
  always_comb begin
    push      = 1'b0;
    push_data = pend_seg_r;
    if (pend_r) begin
      push = !q_stat.full;
    end else if (accept && (have_prev_r || in_last_vertex)) begin
      push      = 1'b1;
      push_data = seg_new;
    end
  end

  // Track polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (pend_r && !q_stat.full) begin
        pend_r <= 1'b0;
      end
      if (accept) begin
        if (!have_prev_r) begin
          have_prev_r <= !in_last_vertex;
        end else if (in_last_vertex) begin
          have_prev_r <= 1'b0;
          pend_r      <= 1'b1;
        end
      end
    end
  end

  // Hold vertex coordinates and the closing segment
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!have_prev_r) begin
        first_x_r <= vx;
        first_y_r <= vy;
      end
      prev_x_r <= vx;
      prev_y_r <= vy;
      pend_seg_r.x0       <= vx;
      pend_seg_r.y0       <= vy;
      pend_seg_r.x1       <= first_x_r;
      pend_seg_r.y1       <= first_y_r;
      pend_seg_r.tag_last <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cplr_back.sv -----
// Line walker: steps Bresenham's algorithm one pixel per cycle while the output is not stalled.
`default_nettype none

module cplr_back
  import cplr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire seg_t   q_head,
  input  wire logic   q_not_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output coord_t      out_pixel_x,
  output coord_t      out_pixel_y,
  output logic        out_last_pixel
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_WALK = 2'b10
  } bstate_t;

  localparam int W8 = ERR_W + 1;

  bstate_t state_r, state_nxt;
  coord_t  walk_x_r, walk_y_r, end_x_r, end_y_r, span_x_r, span_y_r;
  coord_t  span_x_ld, span_y_ld;
  logic [1:0] step_dirs_r;
  logic    tag_r;
  err_t    err_r, err_ld, err_nxt;
  logic    out_valid_r;
  coord_t  out_x_r, out_y_r;
  logic    out_last_r;
  logic    slot_free, emit, at_end, xstep, ystep;
  logic signed [W8-1:0] e8, dx8, dy8, sum8;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (state_r == B_WALK) && slot_free;
  assign at_end    = (walk_x_r == end_x_r) && (walk_y_r == end_y_r);
  assign q_pop     = (state_r == B_IDLE) && q_not_empty;

  // Set up spans and initial error for the head segment
  always_comb begin
    span_x_ld = (q_head.x1 > q_head.x0) ? q_head.x1 - q_head.x0 : q_head.x0 - q_head.x1;
    span_y_ld = (q_head.y1 > q_head.y0) ? q_head.y1 - q_head.y0 : q_head.y0 - q_head.y1;
    if (span_x_ld > span_y_ld) begin
      err_ld = ERR_W'({1'b0, span_x_ld >> 1});
    end else begin
      err_ld = -ERR_W'({1'b0, span_y_ld >> 1});
    end
  end

  // One Bresenham step
  always_comb begin
    e8    = W8'(err_r);
    dx8   = W8'({1'b0, span_x_r});
    dy8   = W8'({1'b0, span_y_r});
    xstep = e8 > -dx8;
    ystep = e8 < dy8;
    sum8  = e8 - (xstep ? dy8 : '0) + (ystep ? dx8 : '0);
    err_nxt = sum8[ERR_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (q_not_empty) state_nxt = B_WALK;
      B_WALK:  if (emit && at_end) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load a segment, then advance the walk as pixels go out
  always_ff @(posedge clk) begin
    if (q_pop) begin
      walk_x_r    <= q_head.x0;
      walk_y_r    <= q_head.y0;
      end_x_r     <= q_head.x1;
      end_y_r     <= q_head.y1;
      span_x_r    <= span_x_ld;
      span_y_r    <= span_y_ld;
      step_dirs_r <= {q_head.y0 >= q_head.y1, q_head.x0 >= q_head.x1};
      tag_r       <= q_head.tag_last;
      err_r       <= err_ld;
    end else if (emit && !at_end) begin
      err_r <= err_nxt;
      if (xstep) walk_x_r <= step_dirs_r[0] ? walk_x_r - 1'b1 : walk_x_r + 1'b1;
      if (ystep) walk_y_r <= step_dirs_r[1] ? walk_y_r - 1'b1 : walk_y_r + 1'b1;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= walk_x_r;
      out_y_r    <= walk_y_r;
      out_last_r <= at_end && tag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_last_pixel = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/closed_polygon_line_rasterizer_core.sv -----
// Closed polygon outline rasterizer top level: front end, queue, walker.
// First pixel path: segment queue, walker segment registers, output word register.
// Throughput: one pixel per cycle while walking and out_ready holds, plus a setup step
// in the walker's idle state to load each segment from the queue.
// A four-entry segment queue lets the front end take vertices while the walker is busy.
// Reset (rst_n low, synchronous) empties the queue and starts a new polygon.
`default_nettype none

module closed_polygon_line_rasterizer_core
  import cplr_pkg::*;
#(
  parameter int GRID_SIZE = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire coord_t in_vertex_x,
  input  wire coord_t in_vertex_y,
  input  wire logic   in_last_vertex,
  output logic        out_valid,
  input  wire logic   out_ready,
  output coord_t      out_pixel_x,
  output coord_t      out_pixel_y,
  output logic        out_last_pixel
);

  q_stat_t q_stat;
  logic    push, pop, q_not_empty;
  seg_t    push_data, q_head;

  cplr_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  cplr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .stat      (q_stat)
  );

  cplr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_not_empty    (q_not_empty),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

endmodule

`default_nettype wire

// ----- sim/tb_closed_polygon_line_rasterizer_core.sv -----
// Self-checking testbench for the closed polygon outline rasterizer core.
`timescale 1ns / 1ps

module tb_closed_polygon_line_rasterizer_core;
  import cplr_pkg::*;

  localparam int GRID_SIZE  = 32;
  localparam int MAX_REPORT = 20;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Outline predictor and store of pixels still owed by the block
  class pixel_scoreboard;
    coord_t first_x, first_y, prev_x, prev_y;
    bit     have_prev;
    pixel_t expected_pixels[$];
    pixel_t held_pixel;
    bit     have_held;
    int     mismatches;
    int     vertex_count;
    int     pixel_count;

    function new();
      have_prev    = 1'b0;
      have_held    = 1'b0;
      first_x      = '0;
      first_y      = '0;
      prev_x       = '0;
      prev_y       = '0;
      mismatches   = 0;
      vertex_count = 0;
      pixel_count  = 0;
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORT) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Hold back the newest pixel so the final one of a vertex can be flagged
    function void add_pixel(int x, int y);
      if (have_held) expected_pixels.push_back(held_pixel);
      held_pixel.x    = coord_t'(x);
      held_pixel.y    = coord_t'(y);
      held_pixel.last = 1'b0;
      have_held       = 1'b1;
    endfunction

    // Bresenham walk, both endpoints included
    function void trace_segment(int x0, int y0, int x1, int y1);
      int span_x, span_y, dir_x, dir_y, err, e2, wx, wy, n;
      span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
      span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
      dir_x  = (x0 < x1) ? 1 : -1;
      dir_y  = (y0 < y1) ? 1 : -1;
      err    = ((span_x > span_y) ? span_x : -span_y) / 2;
      wx     = x0;
      wy     = y0;
      for (n = 0; n <= GRID_SIZE; n++) begin
        add_pixel(wx, wy);
        if (wx == x1 && wy == y1) break;
        e2 = err;
        if (e2 > -span_x) begin
          err -= span_y;
          wx  += dir_x;
        end
        if (e2 < span_y) begin
          err += span_x;
          wy  += dir_y;
        end
      end
    endfunction

    function void note_vertex(coord_t in_x, coord_t in_y, logic in_last);
      coord_t vx, vy;
      vx = (int'(in_x) >= GRID_SIZE) ? coord_t'(GRID_SIZE - 1) : in_x;
      vy = (int'(in_y) >= GRID_SIZE) ? coord_t'(GRID_SIZE - 1) : in_y;
      vertex_count++;
      if (!have_prev) begin
        first_x = vx;
        first_y = vy;
        if (in_last) begin
          add_pixel(vx, vy);
        end else begin
          prev_x    = vx;
          prev_y    = vy;
          have_prev = 1'b1;
        end
      end else begin
        trace_segment(prev_x, prev_y, vx, vy);
        if (in_last) begin
          // closing edge back to the first vertex
          trace_segment(vx, vy, first_x, first_y);
          have_prev = 1'b0;
        end else begin
          prev_x = vx;
          prev_y = vy;
        end
      end
      // flag the final pixel caused by this vertex
      if (have_held) begin
        held_pixel.last = 1'b1;
        expected_pixels.push_back(held_pixel);
        have_held = 1'b0;
      end
    endfunction

    function void check_pixel(coord_t px, coord_t py, logic plast);
      pixel_t exp_pix;
      pixel_count++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) last=%0b with nothing expected",
                                  px, py, plast));
      end else begin
        exp_pix = expected_pixels.pop_front();
        if (px !== exp_pix.x || py !== exp_pix.y || plast !== exp_pix.last)
          report_mismatch($sformatf("pixel got (%0d,%0d) last=%0b, want (%0d,%0d) last=%0b",
                                    px, py, plast, exp_pix.x, exp_pix.y, exp_pix.last));
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  coord_t in_vertex_x;
  coord_t in_vertex_y;
  logic   in_last_vertex;
  logic   out_valid;
  logic   out_ready;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_last_pixel;

  pixel_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  closed_polygon_line_rasterizer_core #(
    .GRID_SIZE(GRID_SIZE)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_vertex_x   (in_vertex_x),
    .in_vertex_y   (in_vertex_y),
    .in_last_vertex(in_last_vertex),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stalls, plus a long hold when one is requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  // Check every pixel word taken from the block
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_pixel(out_pixel_x, out_pixel_y, out_last_pixel);
  end

  // Offer one vertex word and hold it until taken
  task automatic send_vertex(coord_t vx, coord_t vy, logic vlast);
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_vertex_x    <= vx;
    in_vertex_y    <= vy;
    in_last_vertex <= vlast;
    do @(posedge clk); while (!in_ready);
    sb.note_vertex(vx, vy, vlast);
  endtask

  // Drop valid and wait until every owed pixel has come out
  task automatic drain_pixels(int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Bias toward the grid edges
  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return coord_t'(GRID_SIZE - 1);
      default: return coord_t'($urandom_range(GRID_SIZE - 1));
    endcase
  endfunction

  // Random closed polygon; sometimes a single vertex or a repeated one
  task automatic send_polygon(output int sent);
    int     n_verts, k;
    coord_t vx, vy;
    n_verts = ($urandom_range(9) == 0) ? 1 : int'($urandom_range(7, 2));
    vx = pick_coord();
    vy = pick_coord();
    for (k = 0; k < n_verts; k++) begin
      if ($urandom_range(19) != 0) begin
        vx = pick_coord();
        vy = pick_coord();
      end
      send_vertex(vx, vy, k == n_verts - 1);
    end
    sent = n_verts;
  endtask

  // Random polygons until the phase has used its share of vertices
  task automatic run_phase(int send_pct, int recv_pct, int budget);
    int used, sent;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    used = 0;
    while (used < budget) begin
      send_polygon(sent);
      used += sent;
    end
    drain_pixels(8);
  endtask

  initial begin
    int sent;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_vertex_x    = '0;
    in_vertex_y    = '0;
    in_last_vertex = 1'b0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-vertex polygons at an inner point and at the far corner
    send_vertex(5'd5, 5'd7, 1'b1);
    send_vertex(5'd31, 5'd31, 1'b1);
    // Full diagonals; closing edge collapses to one pixel
    send_vertex(5'd0, 5'd0, 1'b0);
    send_vertex(5'd31, 5'd31, 1'b0);
    send_vertex(5'd31, 5'd0, 1'b0);
    send_vertex(5'd0, 5'd31, 1'b0);
    send_vertex(5'd0, 5'd0, 1'b1);
    // Repeated vertices give zero-length edges
    send_vertex(5'd10, 5'd10, 1'b0);
    send_vertex(5'd10, 5'd10, 1'b0);
    send_vertex(5'd20, 5'd12, 1'b0);
    send_vertex(5'd20, 5'd12, 1'b1);
    // Edges in four octants, plus a diagonal and a horizontal edge
    send_vertex(5'd16, 5'd16, 1'b0);
    send_vertex(5'd31, 5'd20, 1'b0);
    send_vertex(5'd20, 5'd31, 1'b0);
    send_vertex(5'd12, 5'd31, 1'b0);
    send_vertex(5'd0, 5'd20, 1'b0);
    send_vertex(5'd3, 5'd0, 1'b0);
    send_vertex(5'd18, 5'd2, 1'b0);
    send_vertex(5'd30, 5'd11, 1'b1);
    // Full-length horizontal edge and a vertical edge
    send_vertex(5'd0, 5'd15, 1'b0);
    send_vertex(5'd31, 5'd15, 1'b0);
    send_vertex(5'd31, 5'd0, 1'b1);
    drain_pixels(8);

    // Long output hold while vertices keep coming, to back up the queue
    hold_request = 400;
    send_polygon(sent);
    send_polygon(sent);
    send_polygon(sent);
    drain_pixels(8);

    run_phase(0, 0, 55);
    run_phase(65, 0, 55);
    run_phase(0, 65, 55);
    run_phase(12, 12, 55);

    drain_pixels(100);

    $display("Covered %0d vertex words and %0d pixel words: single-vertex, repeated,",
             sb.vertex_count, sb.pixel_count);
    $display("all-octant and edge-of-grid polygons, a long output hold and four idling mixes.");
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cplr_pkg.sv
hw/rtl/cplr_fifo.sv
hw/rtl/cplr_front.sv
hw/rtl/cplr_back.sv
hw/rtl/closed_polygon_line_rasterizer_core.sv
sim/tb_closed_polygon_line_rasterizer_core.sv
